/* rtl/core/affine_matrix_inverse_3x3_assert.svh */
// Assertion macros used by the checker of the matrix inverse block.
`ifndef AFFINE_MATRIX_INVERSE_3X3_ASSERT_SVH
`define AFFINE_MATRIX_INVERSE_3X3_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AMXI_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AMXI_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/amxi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package amxi_pkg;

   // Port field geometry.
   localparam int FIELD_BITS  = 32;
   localparam int NUM_ENTRIES = 9;
   localparam int DATA_BITS   = FIELD_BITS * NUM_ENTRIES;
   localparam int USER_BITS   = 2;

   // Bit positions inside the result tuser.
   localparam int USER_SINGULAR  = 0;
   localparam int USER_SATURATED = 1;

   // Diagonal entries of a 3x3 matrix in row-major order.
   localparam logic [NUM_ENTRIES-1:0] DIAG_MASK = 9'b100010001;

   // Adjugate entry k is a[POS_I]*a[POS_J] - a[NEG_I]*a[NEG_J].
   localparam int ADJ_POS_I [NUM_ENTRIES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int ADJ_POS_J [NUM_ENTRIES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int ADJ_NEG_I [NUM_ENTRIES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int ADJ_NEG_J [NUM_ENTRIES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   // First column, used for the determinant expansion.
   localparam int COL0_IDX [3] = '{0, 3, 6};

   typedef logic signed [FIELD_BITS-1:0] field_type;

   // Per-lane status carried through the divider.
   typedef struct packed {
      logic ovf;
      logic neg;
   } div_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/amxi_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bank of pipelined restoring dividers, one lane per matrix entry, sharing
// the divisor. One range check stage, then one quotient bit per stage.
module amxi_div #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    ce,
   input  wire logic [2*WORD_BITS-1:0]  mag  [amxi_pkg::NUM_ENTRIES],
   input  wire logic [amxi_pkg::NUM_ENTRIES-1:0] neg,
   input  wire logic [3*WORD_BITS-1:0]  dmag,
   output logic      [WORD_BITS-1:0]    quot [amxi_pkg::NUM_ENTRIES],
   output amxi_pkg::div_ctl_type        ctl  [amxi_pkg::NUM_ENTRIES]
);

   localparam int W    = WORD_BITS;
   localparam int N    = amxi_pkg::NUM_ENTRIES;
   localparam int MAGB = 2 * W;
   localparam int DB   = 3 * W;
   localparam int NB   = MAGB + 2 * FRAC_BITS;
   localparam int CW   = (NB > DB + W) ? NB : DB + W;

   logic [DB-1:0]         dmag_ff [W+1];
   logic [DB-1:0]         rem_ff  [W+1][N];
   logic [W-1:0]          qn_ff   [W+1][N];
   amxi_pkg::div_ctl_type ctl_ff  [W+1][N];

   logic [CW-1:0] num_wide [N];
   logic [CW-1:0] num_high [N];
   logic [CW-1:0] den_wide;

   logic [DB:0]   trial  [W][N];
   logic [DB+1:0] diff   [W][N];
   logic          qbit_in [W][N];
   logic [DB-1:0] rem_in  [W][N];

   // Scale the numerator and line up the divisor for the range check.
   always_comb begin
      den_wide = {{(CW-DB){1'b0}}, dmag} << W;
      for (int k = 0; k < N; k++) begin
         num_wide[k] = {{(CW-MAGB){1'b0}}, mag[k]} << (2 * FRAC_BITS);
         num_high[k] = num_wide[k] >> W;
      end
   end

   // One compare and subtract per lane and stage.
   always_comb begin
      for (int s = 0; s < W; s++) begin
         for (int k = 0; k < N; k++) begin
            trial[s][k]   = {rem_ff[s][k], qn_ff[s][k][W-1]};
            diff[s][k]    = {1'b0, trial[s][k]} - {2'b00, dmag_ff[s]};
            qbit_in[s][k] = ~diff[s][k][DB+1];
            rem_in[s][k]  = qbit_in[s][k] ? diff[s][k][DB-1:0] : trial[s][k][DB-1:0];
         end
      end
   end

   // A quotient of 2^W or more is flagged and not computed. Numerator bits
   // shift out at the top while quotient bits enter below.
   always_ff @(posedge clock) begin
      if (ce) begin
         dmag_ff[0] <= dmag;
         for (int k = 0; k < N; k++) begin
            rem_ff[0][k]     <= num_high[k][DB-1:0];
            qn_ff[0][k]      <= num_wide[k][W-1:0];
            ctl_ff[0][k].ovf <= (num_wide[k] >= den_wide);
            ctl_ff[0][k].neg <= neg[k];
         end
         for (int s = 0; s < W; s++) begin
            dmag_ff[s+1] <= dmag_ff[s];
            for (int k = 0; k < N; k++) begin
               rem_ff[s+1][k] <= rem_in[s][k];
               qn_ff[s+1][k]  <= {qn_ff[s][k][W-2:0], qbit_in[s][k]};
               ctl_ff[s+1][k] <= ctl_ff[s][k];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < N; k++) begin
         quot[k] = qn_ff[W][k];
         ctl[k]  = ctl_ff[W][k];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/affine_matrix_inverse_3x3.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// req_*     in         tdata: nine matrix entries a00..a22, 32 bits each
// rsp_*     out        tdata: nine entries inv_a00..inv_a22; tuser: singular, saturated
//
// One matrix enters per clock while the pipeline is not held; the seven-stage
// exact determinant path is followed by one divider stage per quotient bit.
// Reset clears all valid bits, those of the output buffers too; data registers
// keep whatever they held. When the output is not taken a two-entry output
// buffer fills, then the whole pipeline holds and req_tready drops.
module affine_matrix_inverse_3x3 #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up
   input  wire logic [amxi_pkg::DATA_BITS-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // inv_a00, inv_a01, inv_a02, inv_a10, ... inv_a22 from the lowest bit up
   output logic      [amxi_pkg::DATA_BITS-1:0]     rsp_tdata,
   // singular, saturated from the lowest bit up
   output logic      [amxi_pkg::USER_BITS-1:0]     rsp_tuser
);

   localparam int W    = WORD_BITS;
   localparam int N    = amxi_pkg::NUM_ENTRIES;
   localparam int FB   = amxi_pkg::FIELD_BITS;
   localparam int PB   = 2 * W;
   localparam int MAGB = 2 * W;
   localparam int DB   = 3 * W;
   localparam int DETB = 3 * W + 1;
   localparam int PIPE = W + 8;

   localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic         DIAG_SAT = (FRAC_BITS > WORD_BITS - 2);
   localparam logic [W-1:0] DIAG_W = DIAG_SAT ? LIM_POS : W'(64'd1 << FRAC_BITS);

   logic ce;
   logic [PIPE-1:0] vld_ff;
   logic [W:0]      sd_ff;

   logic signed [W-1:0]  a_in [N];
   logic signed [W-1:0]  a_ff [N];
   logic signed [PB-1:0] prd_p_in [N];
   logic signed [PB-1:0] prd_n_in [N];
   logic signed [PB-1:0] prd_p_ff [N];
   logic signed [PB-1:0] prd_n_ff [N];
   logic signed [W-1:0]  col1_ff [3];
   logic signed [PB-1:0] adj_ff [N];
   logic signed [W-1:0]  col2_ff [3];
   logic signed [PB:0]   lo_in [3];
   logic signed [PB-1:0] hi_in [3];
   logic signed [PB:0]   lo_ff [3];
   logic signed [PB-1:0] hi_ff [3];
   logic [PB-1:0]        adj_neg [N];
   logic [MAGB-1:0]      mag3_in [N];
   logic [MAGB-1:0]      mag3_ff [N];
   logic [N-1:0]         sgn3_ff;
   logic signed [DETB-1:0] term_in [3];
   logic signed [DETB-1:0] term_ff [3];
   logic [MAGB-1:0]      mag4_ff [N];
   logic [N-1:0]         sgn4_ff;
   logic signed [DETB-1:0] det_ff;
   logic [MAGB-1:0]      mag5_ff [N];
   logic [N-1:0]         sgn5_ff;
   logic                 dneg;
   logic [DETB-1:0]      det_abs;
   logic [DB-1:0]        dmag_ff;
   logic                 sing_ff;
   logic [N-1:0]         eneg_ff;
   logic [MAGB-1:0]      mag6_ff [N];

   logic [W-1:0]          quot [N];
   amxi_pkg::div_ctl_type ctl  [N];

   logic [W-1:0] lim [N];
   logic [W-1:0] clamp_val [N];
   logic [W-1:0] signed_val [N];
   logic [N-1:0] ent_sat;
   logic [amxi_pkg::DATA_BITS-1:0] res_data;
   logic [amxi_pkg::USER_BITS-1:0] res_user;

   logic out_vld_ff, skid_vld_ff;
   logic [amxi_pkg::DATA_BITS-1:0] out_data_ff, skid_data_ff;
   logic [amxi_pkg::USER_BITS-1:0] out_user_ff, skid_user_ff;
   logic take;

   // The pipeline advances whenever the skid entry is free.
   assign ce         = ~skid_vld_ff;
   assign req_tready = ce;
   assign take       = out_vld_ff & rsp_tready;

   // Valid bits and the singular flag travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[PIPE-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sd_ff <= {sd_ff[W-1:0], sing_ff};
      end
   end

   // Stage 0: keep the low word of each field.
   always_comb begin
      for (int k = 0; k < N; k++) begin
         a_in[k] = req_tdata[k*FB +: W];
      end
   end

   // Stage 1: the eighteen 2x2 minor products.
   always_comb begin
      for (int k = 0; k < N; k++) begin
         prd_p_in[k] = a_ff[amxi_pkg::ADJ_POS_I[k]] * a_ff[amxi_pkg::ADJ_POS_J[k]];
         prd_n_in[k] = a_ff[amxi_pkg::ADJ_NEG_I[k]] * a_ff[amxi_pkg::ADJ_NEG_J[k]];
      end
   end

   // Stage 3: first-column products split into two halves of the adjugate.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lo_in[j] = col2_ff[j] * $signed({1'b0, adj_ff[j][W-1:0]});
         hi_in[j] = col2_ff[j] * $signed(adj_ff[j][PB-1:W]);
      end
      for (int k = 0; k < N; k++) begin
         adj_neg[k] = -adj_ff[k];
         mag3_in[k] = adj_ff[k][PB-1] ? adj_neg[k][MAGB-1:0] : adj_ff[k][MAGB-1:0];
      end
   end

   // Stage 4: join the halves into full cofactor terms.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         term_in[j] = (DETB'(hi_ff[j]) <<< W) + DETB'(lo_ff[j]);
      end
   end

   // Stage 6: determinant magnitude and result signs.
   assign dneg    = det_ff[DETB-1];
   assign det_abs = dneg ? -det_ff : det_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int k = 0; k < N; k++) begin
            a_ff[k]     <= a_in[k];
            prd_p_ff[k] <= prd_p_in[k];
            prd_n_ff[k] <= prd_n_in[k];
            adj_ff[k]   <= prd_p_ff[k] - prd_n_ff[k];
            mag3_ff[k]  <= mag3_in[k];
            mag4_ff[k]  <= mag3_ff[k];
            mag5_ff[k]  <= mag4_ff[k];
            mag6_ff[k]  <= mag5_ff[k];
         end
         for (int j = 0; j < 3; j++) begin
            col1_ff[j] <= a_ff[amxi_pkg::COL0_IDX[j]];
            col2_ff[j] <= col1_ff[j];
            lo_ff[j]   <= lo_in[j];
            hi_ff[j]   <= hi_in[j];
            term_ff[j] <= term_in[j];
         end
         for (int k = 0; k < N; k++) begin
            sgn3_ff[k] <= adj_ff[k][PB-1];
         end
         sgn4_ff <= sgn3_ff;
         sgn5_ff <= sgn4_ff;
         det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         dmag_ff <= det_abs[DB-1:0];
         sing_ff <= (det_ff == '0);
         eneg_ff <= sgn5_ff ^ {N{dneg}};
      end
   end

   amxi_div #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .ce    (ce),
      .mag   (mag6_ff),
      .neg   (eneg_ff),
      .dmag  (dmag_ff),
      .quot  (quot),
      .ctl   (ctl)
   );

   // Clamp, apply sign, and substitute the identity for a singular matrix.
   always_comb begin
      for (int k = 0; k < N; k++) begin
         lim[k]        = ctl[k].neg ? LIM_NEG : LIM_POS;
         ent_sat[k]    = ctl[k].ovf | (quot[k] > lim[k]);
         clamp_val[k]  = ent_sat[k] ? lim[k] : quot[k];
         signed_val[k] = ctl[k].neg ? -clamp_val[k] : clamp_val[k];
         if (sd_ff[W]) begin
            res_data[k*FB +: FB] = amxi_pkg::DIAG_MASK[k] ?
                                   amxi_pkg::field_type'(DIAG_W) : '0;
         end else begin
            res_data[k*FB +: FB] = amxi_pkg::field_type'($signed(signed_val[k]));
         end
      end
      res_user[amxi_pkg::USER_SINGULAR]  = sd_ff[W];
      res_user[amxi_pkg::USER_SATURATED] = sd_ff[W] ? DIAG_SAT : |ent_sat;
   end

   // Output register with one skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (ce) begin
         if (vld_ff[PIPE-1]) begin
            if (!out_vld_ff || take) begin
               out_vld_ff <= 1'b1;
            end else begin
               skid_vld_ff <= 1'b1;
            end
         end else if (take) begin
            out_vld_ff <= 1'b0;
         end
      end else if (take) begin
         skid_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         if (!out_vld_ff || take) begin
            out_data_ff <= res_data;
            out_user_ff <= res_user;
         end else begin
            skid_data_ff <= res_data;
            skid_user_ff <= res_user;
         end
      end else if (take) begin
         out_data_ff <= skid_data_ff;
         out_user_ff <= skid_user_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

/* rtl/core/amxi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "affine_matrix_inverse_3x3_assert.svh"

// Port-level checks on the matrix inverse block.
module amxi_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [amxi_pkg::DATA_BITS-1:0] rsp_tdata,
   input wire logic [amxi_pkg::USER_BITS-1:0] rsp_tuser
);

   logic [7:0] outst_ff;
   logic [7:0] outst_in;

   // Count transactions taken in but not yet delivered.
   assign outst_in = outst_ff + 8'(req_tvalid & req_tready) - 8'(rsp_tvalid & rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   `AMXI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")
   `AMXI_ASSERT_IMP(a_no_extra, clock, reset, rsp_tvalid, outst_ff != 8'd0, "result without a pending input")
   `AMXI_ASSERT_IMP(a_ready_low, clock, reset, !req_tready, rsp_tvalid, "input stalled with no result waiting")
   `AMXI_ASSERT_IMP(a_identity, clock, reset, rsp_tvalid && rsp_tuser[amxi_pkg::USER_SINGULAR], (rsp_tdata[127:32] == 96'd0) && (rsp_tdata[255:160] == 96'd0), "singular result is not the identity")

endmodule

bind affine_matrix_inverse_3x3 amxi_checker u_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

// Holds the expected inverse of every accepted matrix and checks each result
// transaction against the oldest one.
class inverse_scoreboard;
   logic [amxi_pkg::DATA_BITS-1:0] inv_q[$];
   logic [amxi_pkg::USER_BITS-1:0] flag_q[$];
   int mismatches = 0;

   // Exact adjugate and determinant, then a truncating divide and clamp per entry.
   function void note_matrix(logic [amxi_pkg::DATA_BITS-1:0] mat);
      logic signed [63:0] a [9];
      logic signed [63:0] adj [9];
      logic signed [127:0] det, wa, wj;
      logic [127:0] dmag, quo, lim;
      logic [63:0] mag;
      logic [amxi_pkg::DATA_BITS-1:0] inv;
      logic dneg, neg, sat;
      for (int k = 0; k < 9; k++) a[k] = $signed(mat[32*k +: 32]);
      adj[0] = a[4] * a[8] - a[5] * a[7];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[4] * a[6];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      det = 0;
      for (int k = 0; k < 3; k++) begin
         wa = a[3*k];
         wj = adj[k];
         det = det + wa * wj;
      end
      inv = '0;
      sat = 1'b0;
      if (det == 0) begin
         // A singular matrix yields the identity.
         for (int k = 0; k < 9; k += 4) inv[32*k +: 32] = 32'h0001_0000;
         inv_q.push_back(inv);
         flag_q.push_back(2'b01);
         return;
      end
      dneg = det[127];
      dmag = dneg ? -det : det;
      for (int k = 0; k < 9; k++) begin
         mag = adj[k][63] ? -adj[k] : adj[k];
         quo = {64'b0, mag} << 32;
         quo = quo / dmag;
         neg = adj[k][63] ^ dneg;
         lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
         if (quo > lim) begin
            quo = lim;
            sat = 1'b1;
         end
         inv[32*k +: 32] = neg ? -quo[31:0] : quo[31:0];
      end
      inv_q.push_back(inv);
      flag_q.push_back({sat, 1'b0});
   endfunction

   function void check_inverse(logic [amxi_pkg::DATA_BITS-1:0] inv,
                               logic [amxi_pkg::USER_BITS-1:0] flags);
      logic [amxi_pkg::DATA_BITS-1:0] exp_inv;
      logic [amxi_pkg::USER_BITS-1:0] exp_flags;
      if (inv_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result: tdata=%h tuser=%b", inv, flags);
         return;
      end
      exp_inv = inv_q.pop_front();
      exp_flags = flag_q.pop_front();
      for (int k = 0; k < 9; k++) begin
         if (inv[32*k +: 32] !== exp_inv[32*k +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Entry %0d mismatch: expected %h, got %h", k,
                        exp_inv[32*k +: 32], inv[32*k +: 32]);
         end
      end
      if (flags[amxi_pkg::USER_SINGULAR] !== exp_flags[amxi_pkg::USER_SINGULAR]) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Singular mismatch: expected %b, got %b",
                     exp_flags[amxi_pkg::USER_SINGULAR], flags[amxi_pkg::USER_SINGULAR]);
      end
      if (flags[amxi_pkg::USER_SATURATED] !== exp_flags[amxi_pkg::USER_SATURATED]) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Saturated mismatch: expected %b, got %b",
                     exp_flags[amxi_pkg::USER_SATURATED], flags[amxi_pkg::USER_SATURATED]);
      end
   endfunction

   function int pending();
      return inv_q.size();
   endfunction
endclass

module tb_top;
   localparam int ONE = 32'h0001_0000;
   localparam int IDLE_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 1250;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [amxi_pkg::DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [amxi_pkg::DATA_BITS-1:0] rsp_tdata;
   logic [amxi_pkg::USER_BITS-1:0] rsp_tuser;

   inverse_scoreboard sb = new();
   bit hold_output = 1'b0;
   bit no_idle = 1'b0;
   int idle_cycles = 0;

   affine_matrix_inverse_3x3 dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on cycles in which no transaction completes on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("affine_matrix_inverse_3x3 verification failed");
            $finish;
         end
      end
   end

   // Result side: random stalls, one long hold on request.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 6);
         if (hold_output) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_output = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_tvalid || !rsp_tready);
         sb.check_inverse(rsp_tdata, rsp_tuser);
      end
   end

   task automatic send_matrix(input logic [31:0] m [9]);
      int gap;
      logic [amxi_pkg::DATA_BITS-1:0] packed_mat;
      for (int k = 0; k < 9; k++) packed_mat[32*k +: 32] = m[k];
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= packed_mat;
      do @(posedge clock); while (!req_tready);
      sb.note_matrix(packed_mat);
   endtask

   task automatic send_rows(input logic [31:0] r0, r1, r2, r3, r4, r5, r6, r7, r8);
      logic [31:0] m [9];
      m = '{r0, r1, r2, r3, r4, r5, r6, r7, r8};
      send_matrix(m);
   endtask

   // Draws one matrix; two in five are well-formed affine transforms.
   task automatic send_random();
      logic [31:0] m [9];
      int kind;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) m[k] = $urandom;
      case (kind)
         0, 1, 2, 3: begin
            // Affine transform of moderate scale.
            for (int k = 0; k < 6; k++) m[k] = $signed($urandom_range(0, 32'h7ffff)) - 32'h40000;
            m[6] = 0;
            m[7] = 0;
            m[8] = ONE;
         end
         4: begin
            // Small integers give many exact and many saturated entries.
            for (int k = 0; k < 9; k++) m[k] = $signed($urandom_range(0, 8)) - 4;
         end
         5: begin
            // Two equal rows make the matrix singular.
            m[6] = m[0];
            m[7] = m[1];
            m[8] = m[2];
         end
         6: begin
            for (int k = 0; k < 9; k++)
               m[k] = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         end
         default: begin
         end
      endcase
      send_matrix(m);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases: identity, zero, extremes, negative determinant, saturation.
      send_rows(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
      send_rows(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_rows(ONE, 0, 32'h0050_0000, 0, ONE, 32'hffd8_0000, 0, 0, ONE);
      send_rows(2 * ONE, 0, 0, 0, 32'hfffe_0000, 0, 0, 0, ONE);
      send_rows(1, 0, 0, 0, 1, 0, 0, 0, 1);
      send_rows(32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff);
      send_rows(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000);
      send_rows(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_rows(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, ONE);
      send_rows(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_rows(0, ONE, 0, ONE, 0, 0, 0, 0, ONE);
      send_rows(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 10 * ONE);
      send_rows(0, 0, 1, 0, 1, 0, 1, 0, 0);
      send_rows(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0);
      send_rows(ONE, 32'h0000_8000, 0, 32'hffff_8000, ONE, 0, 0, 0, 32'h7fff_ffff);

      // Sender waits until every expected result has come back.
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      // Back-to-back traffic with no idling on either side.
      no_idle = 1'b1;
      repeat (100) send_random();
      no_idle = 1'b0;

      // Receiver holds off while the sender keeps offering matrices.
      hold_output = 1'b1;
      repeat (100) send_random();

      repeat (RANDOM_ITEMS - 200) send_random();
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("affine_matrix_inverse_3x3 verification clean");
      end else begin
         $display("affine_matrix_inverse_3x3 verification failed");
      end
      $finish;
   end
endmodule
